[sv/tstq_pkg.sv]
`timescale 1ns / 1ps

package tstq_pkg;

    localparam int OP_W     = 3;
    localparam int LIB_W    = 8;
    localparam int TASK_W   = 8;
    localparam int CNT_W    = 3;
    localparam int ARG_W    = 8;
    localparam int ARG_N    = 4;
    localparam int ARGS_W   = ARG_W * ARG_N;
    localparam int STAT_W   = 2;
    localparam int OTIME_W  = 32;
    localparam int ECNT_W   = 5;
    localparam int ENTRY_FIX_W = LIB_W + TASK_W + CNT_W + ARGS_W;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_POP    = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic lt;
        logic hit;
    } t_cmp_res;

endpackage

[sv/timestamp_sorted_task_queue.sv]
`timescale 1ns / 1ps
// Steps: insert walks down from the tail moving later entries up, writing at the head directly;
// remove scans from the head, then shifts later entries down; pop reads the head, then shifts;
// peek reads the head; clear, full insert and empty pop or peek go to finish; then output wait.
// Throughput: one transaction at a time; every slot visit costs a RAM read through the single
// slot RAM port pair, and insert and remove visits a compare through the shared compare unit.
// Reset: synchronous active low; clears occupancy and control, slot RAM contents undefined.
module timestamp_sorted_task_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_ARGS    = 4,
    parameter int TIME_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op, due_time, library_id, task_id, arg_count, arg_zero, arg_one, arg_two, arg_three
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, out_due_time, out_library_id, out_task_id, out_arg_count, out_arg_zero,
    // out_arg_one, out_arg_two, out_arg_three, queue_empty, entry_count
    output logic [95:0] m_axis_tdata
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int EW    = TIME_WIDTH + tstq_pkg::ENTRY_FIX_W;
    localparam int TW_IN = (TIME_WIDTH < tstq_pkg::OTIME_W) ? TIME_WIDTH : tstq_pkg::OTIME_W;
    localparam int RW    = tstq_pkg::STAT_W + tstq_pkg::OTIME_W + tstq_pkg::ENTRY_FIX_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INS_RD  = 4'd1;
    localparam logic [3:0] ST_INS_EV  = 4'd2;
    localparam logic [3:0] ST_REM_RD  = 4'd3;
    localparam logic [3:0] ST_REM_EV  = 4'd4;
    localparam logic [3:0] ST_SH_RD   = 4'd5;
    localparam logic [3:0] ST_SH_EV   = 4'd6;
    localparam logic [3:0] ST_HEAD_RD = 4'd7;
    localparam logic [3:0] ST_HEAD_EV = 4'd8;
    localparam logic [3:0] ST_FIN     = 4'd9;

    logic [3:0]              r_state, n_state;
    logic [tstq_pkg::OP_W-1:0] r_op, n_op;
    logic [EW-1:0]           r_key, n_key;
    logic [CW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_occ, n_occ;
    logic [RW-1:0]           r_res, n_res;
    logic                    r_ovalid, n_ovalid;
    logic [95:0]             r_odata, n_odata;

    logic                    w_we;
    logic [AW-1:0]           w_waddr, w_raddr;
    logic [EW-1:0]           w_wdata, w_rdata, w_in_entry;
    logic [CW-1:0]           w_idx_dn, w_idx_up;
    logic                    w_accept;
    tstq_pkg::t_cmp_res      w_cmp;

    logic [tstq_pkg::OP_W-1:0]   in_op;
    logic [tstq_pkg::OTIME_W-1:0] in_time;

    assign in_op   = s_axis_tdata[2:0];
    assign in_time = s_axis_tdata[34:3];
    assign w_in_entry = {s_axis_tdata[85:54], s_axis_tdata[53:51], s_axis_tdata[50:43],
                         s_axis_tdata[42:35], TIME_WIDTH'(in_time[TW_IN-1:0])};

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_idx_dn      = r_idx - CW'(1);
    assign w_idx_up      = r_idx + CW'(1);

    tstq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tstq_cmp #(
        .TIME_WIDTH (TIME_WIDTH),
        .MAX_ARGS   (MAX_ARGS)
    ) u_cmp (
        .i_key_time  (r_key[TIME_WIDTH-1:0]),
        .i_key_lib   (r_key[TIME_WIDTH +: tstq_pkg::LIB_W]),
        .i_key_task  (r_key[TIME_WIDTH+8 +: tstq_pkg::TASK_W]),
        .i_key_cnt   (r_key[TIME_WIDTH+16 +: tstq_pkg::CNT_W]),
        .i_key_args  (r_key[TIME_WIDTH+19 +: tstq_pkg::ARGS_W]),
        .i_slot_time (w_rdata[TIME_WIDTH-1:0]),
        .i_slot_lib  (w_rdata[TIME_WIDTH +: tstq_pkg::LIB_W]),
        .i_slot_task (w_rdata[TIME_WIDTH+8 +: tstq_pkg::TASK_W]),
        .i_slot_cnt  (w_rdata[TIME_WIDTH+16 +: tstq_pkg::CNT_W]),
        .i_slot_args (w_rdata[TIME_WIDTH+19 +: tstq_pkg::ARGS_W]),
        .o_res       (w_cmp)
    );

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_idx    = r_idx;
        n_occ    = r_occ;
        n_res    = r_res;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        w_we     = 1'b0;
        w_waddr  = r_idx[AW-1:0];
        w_wdata  = r_key;
        w_raddr  = r_idx[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op  = in_op;
                    n_key = w_in_entry;
                    n_res = '0;
                    case (in_op)
                        tstq_pkg::OP_INSERT: begin
                            if (r_occ == CW'(QUEUE_DEPTH)) begin
                                n_res[tstq_pkg::STAT_W-1:0] = tstq_pkg::STAT_OVERFLOW;
                                n_state = ST_FIN;
                            end else begin
                                n_idx   = r_occ;
                                n_state = ST_INS_RD;
                            end
                        end
                        tstq_pkg::OP_REMOVE: begin
                            n_idx   = '0;
                            n_state = ST_REM_RD;
                        end
                        tstq_pkg::OP_POP, tstq_pkg::OP_PEEK: begin
                            n_idx = '0;
                            if (r_occ == '0) begin
                                n_res[tstq_pkg::STAT_W-1:0] = tstq_pkg::STAT_NOTFOUND;
                                n_state = ST_FIN;
                            end else begin
                                n_state = ST_HEAD_RD;
                            end
                        end
                        tstq_pkg::OP_CLEAR: begin
                            n_occ   = '0;
                            n_state = ST_FIN;
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_INS_RD: begin
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    n_occ   = r_occ + CW'(1);
                    n_state = ST_FIN;
                end else begin
                    w_raddr = w_idx_dn[AW-1:0];
                    n_state = ST_INS_EV;
                end
            end
            ST_INS_EV: begin
                w_we = 1'b1;
                if (w_cmp.lt) begin
                    w_wdata = w_rdata;
                    n_idx   = w_idx_dn;
                    n_state = ST_INS_RD;
                end else begin
                    n_occ   = r_occ + CW'(1);
                    n_state = ST_FIN;
                end
            end
            ST_REM_RD: begin
                if (r_idx == r_occ) begin
                    n_res[tstq_pkg::STAT_W-1:0] = tstq_pkg::STAT_NOTFOUND;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_REM_EV;
                end
            end
            ST_REM_EV: begin
                if (w_cmp.hit) begin
                    n_state = ST_SH_RD;
                end else begin
                    n_idx   = w_idx_up;
                    n_state = ST_REM_RD;
                end
            end
            ST_SH_RD: begin
                if (w_idx_up >= r_occ) begin
                    n_occ   = r_occ - CW'(1);
                    n_state = ST_FIN;
                end else begin
                    w_raddr = w_idx_up[AW-1:0];
                    n_state = ST_SH_EV;
                end
            end
            ST_SH_EV: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                n_idx   = w_idx_up;
                n_state = ST_SH_RD;
            end
            ST_HEAD_RD: begin
                n_state = ST_HEAD_EV;
            end
            ST_HEAD_EV: begin
                n_res = {w_rdata[EW-1:TIME_WIDTH],
                         tstq_pkg::OTIME_W'(w_rdata[TW_IN-1:0]), tstq_pkg::STAT_DONE};
                n_state = (r_op == tstq_pkg::OP_POP) ? ST_SH_RD : ST_FIN;
            end
            ST_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {5'd0, tstq_pkg::ECNT_W'(r_occ), (r_occ == '0), r_res};
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_key   <= n_key;
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS_RD || r_state == ST_INS_EV) |-> (r_occ < CW'(QUEUE_DEPTH)))
        else $error("insert walk on a full queue");

    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SH_RD || r_state == ST_SH_EV) |-> (r_occ != '0) && (r_idx < r_occ))
        else $error("delete shift outside held entries");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_ovalid && !(r_ovalid && !m_axis_tready)) |-> (r_state == ST_FIN))
        else $error("result loaded outside finish step");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == tstq_pkg::STAT_OVERFLOW) |->
        (m_axis_tdata[90:86] == tstq_pkg::ECNT_W'(QUEUE_DEPTH)))
        else $error("overflow reported with room left");

endmodule

[sv/tstq_ram.sv]
`timescale 1ns / 1ps

module tstq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 83
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/tstq_cmp.sv]
`timescale 1ns / 1ps

module tstq_cmp #(
    parameter int TIME_WIDTH = 32,
    parameter int MAX_ARGS   = 4
) (
    input  logic [TIME_WIDTH-1:0]           i_key_time,
    input  logic [tstq_pkg::LIB_W-1:0]      i_key_lib,
    input  logic [tstq_pkg::TASK_W-1:0]     i_key_task,
    input  logic [tstq_pkg::CNT_W-1:0]      i_key_cnt,
    input  logic [tstq_pkg::ARGS_W-1:0]     i_key_args,
    input  logic [TIME_WIDTH-1:0]           i_slot_time,
    input  logic [tstq_pkg::LIB_W-1:0]      i_slot_lib,
    input  logic [tstq_pkg::TASK_W-1:0]     i_slot_task,
    input  logic [tstq_pkg::CNT_W-1:0]      i_slot_cnt,
    input  logic [tstq_pkg::ARGS_W-1:0]     i_slot_args,
    output tstq_pkg::t_cmp_res              o_res
);

    always_comb begin
        o_res.lt  = (i_key_time < i_slot_time);
        o_res.hit = (i_key_lib == i_slot_lib) && (i_key_task == i_slot_task) &&
                    (i_key_cnt == i_slot_cnt);
        for (int b = 0; b < tstq_pkg::ARG_N; b++) begin
            if ((b < MAX_ARGS) && (tstq_pkg::CNT_W'(b) < i_key_cnt) &&
                (i_key_args[b*tstq_pkg::ARG_W +: tstq_pkg::ARG_W] !=
                 i_slot_args[b*tstq_pkg::ARG_W +: tstq_pkg::ARG_W])) begin
                o_res.hit = 1'b0;
            end
        end
    end

endmodule
